FILE: rtl/nrcw_pkg.sv
package nrcw_pkg;

  localparam int unsigned TIME_BITS   = 48;
  localparam int unsigned MD_BITS     = 16;
  localparam int unsigned BYTES_BITS  = 16;
  localparam int unsigned CWND_BITS   = 27;
  localparam int unsigned THRESH_BITS = 28;
  localparam int unsigned CREDIT_BITS = 28;
  localparam int unsigned COUNT_BITS  = 32;
  // working width of the avoidance loop, one bit above credit
  localparam int unsigned WORK_BITS   = CREDIT_BITS + 1;
  localparam int unsigned IW_BITS     = MD_BITS + 4;
  localparam int unsigned ADDR_BITS   = 3;
  localparam int unsigned DATA_BITS   = 32;

  localparam logic [CWND_BITS-1:0]   WINDOW_CEILING   = 27'd67108864;
  localparam logic [MD_BITS-1:0]     INITIAL_FLOOR    = 16'd14720;
  localparam logic [MD_BITS-1:0]     RESET_DATAGRAM   = 16'd1200;
  localparam logic [THRESH_BITS-1:0] THRESH_UNLIMITED = '1;

  // register index within the config space (byte address 4*index)
  localparam logic [0:0] REG_MAX_DATAGRAM = 1'b0;

  typedef enum logic [1:0] {
    KIND_ACKED   = 2'd0,
    KIND_SIGNAL  = 2'd1,
    KIND_PERSIST = 2'd2,
    KIND_RESET   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOOP,
    ST_CLAMP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic latch;
    logic ack_slow;
    logic ack_avoid;
    logic loop_step;
    logic clamp;
    logic cut;
    logic collapse;
    logic restart;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  stale;
    logic  limited;
    logic  slow_start;
    logic  credit_ge;
  } dp_status_t;

  // min(10*md, max(2*md, INITIAL_FLOOR))
  function automatic logic [CWND_BITS-1:0] initial_window(input logic [MD_BITS-1:0] md);
    logic [IW_BITS-1:0] ten;
    logic [IW_BITS-1:0] lo;
    logic [IW_BITS-1:0] flr;
    ten = {1'b0, md, 3'b000} + {3'b000, md, 1'b0};
    lo  = {3'b000, md, 1'b0};
    flr = {4'b0000, INITIAL_FLOOR};
    if (lo < flr) begin
      lo = flr;
    end
    return CWND_BITS'((ten < lo) ? ten : lo);
  endfunction

  localparam logic [CWND_BITS-1:0] RESET_WINDOW = initial_window(RESET_DATAGRAM);

endpackage

FILE: rtl/nrcw_ctrl.sv
module nrcw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  nrcw_pkg::dp_status_t status,
  output nrcw_pkg::dp_cmd_t    cmd
);

  nrcw_pkg::state_t state;
  nrcw_pkg::state_t state_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == nrcw_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nrcw_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nrcw_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = nrcw_pkg::ST_EXEC;
        end
      end
      nrcw_pkg::ST_EXEC: begin
        state_next = nrcw_pkg::ST_FINISH;
        if (status.kind == nrcw_pkg::KIND_ACKED && !status.stale && !status.limited) begin
          state_next = status.slow_start ? nrcw_pkg::ST_CLAMP : nrcw_pkg::ST_LOOP;
        end
      end
      nrcw_pkg::ST_LOOP: begin
        if (!status.credit_ge) begin
          state_next = nrcw_pkg::ST_CLAMP;
        end
      end
      nrcw_pkg::ST_CLAMP: begin
        state_next = nrcw_pkg::ST_FINISH;
      end
      nrcw_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = nrcw_pkg::ST_IDLE;
        end
      end
      default: state_next = nrcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      nrcw_pkg::ST_IDLE: begin
        cmd.latch = in_valid;
      end
      nrcw_pkg::ST_EXEC: begin
        unique case (status.kind)
          nrcw_pkg::KIND_ACKED: begin
            if (!status.stale && !status.limited) begin
              cmd.ack_slow  = status.slow_start;
              cmd.ack_avoid = !status.slow_start;
            end
          end
          nrcw_pkg::KIND_SIGNAL:  cmd.cut      = !status.stale;
          nrcw_pkg::KIND_PERSIST: cmd.collapse = 1'b1;
          nrcw_pkg::KIND_RESET:   cmd.restart  = 1'b1;
          default: ;
        endcase
      end
      nrcw_pkg::ST_LOOP: begin
        cmd.loop_step = status.credit_ge;
      end
      nrcw_pkg::ST_CLAMP: begin
        cmd.clamp = 1'b1;
      end
      nrcw_pkg::ST_FINISH: begin
        cmd.publish = out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/nrcw_dp.sv
module nrcw_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  nrcw_pkg::dp_cmd_t                 cmd,
  output nrcw_pkg::dp_status_t              status,
  input  logic [nrcw_pkg::MD_BITS-1:0]      max_datagram,
  input  logic [1:0]                        kind,
  input  logic [nrcw_pkg::BYTES_BITS-1:0]   packet_bytes,
  input  logic [nrcw_pkg::TIME_BITS-1:0]    packet_sent_time,
  input  logic [nrcw_pkg::TIME_BITS-1:0]    now_time,
  input  logic                              app_limited,
  output logic [nrcw_pkg::CWND_BITS-1:0]    cwnd_bytes,
  output logic [nrcw_pkg::THRESH_BITS-1:0]  slow_start_threshold,
  output logic                              recovering,
  output logic                              cut_applied,
  output logic [nrcw_pkg::COUNT_BITS-1:0]   cut_count
);

  // latched item
  nrcw_pkg::kind_t                    item_kind;
  logic [nrcw_pkg::BYTES_BITS-1:0]    item_bytes;
  logic [nrcw_pkg::TIME_BITS-1:0]     item_sent;
  logic [nrcw_pkg::TIME_BITS-1:0]     item_now;
  logic                               item_limited;

  // window state
  logic [nrcw_pkg::CWND_BITS-1:0]     cwnd;
  logic [nrcw_pkg::THRESH_BITS-1:0]   ssthresh;
  logic [nrcw_pkg::CREDIT_BITS-1:0]   credit;
  logic                               in_recovery;
  logic [nrcw_pkg::TIME_BITS-1:0]     recovery_start;
  logic [nrcw_pkg::COUNT_BITS-1:0]    cuts_total;
  logic                               cut_flag;

  // avoidance loop working registers
  logic [nrcw_pkg::WORK_BITS-1:0]     work_cwnd;
  logic [nrcw_pkg::WORK_BITS-1:0]     work_credit;

  logic [nrcw_pkg::MD_BITS:0]         floor2;
  logic [nrcw_pkg::THRESH_BITS-1:0]   half_cwnd;
  logic [nrcw_pkg::THRESH_BITS-1:0]   cut_thresh;
  logic [nrcw_pkg::CWND_BITS-1:0]     clamped;

  assign floor2     = {max_datagram, 1'b0};
  assign half_cwnd  = nrcw_pkg::THRESH_BITS'(cwnd >> 1);
  assign cut_thresh = (half_cwnd < nrcw_pkg::THRESH_BITS'(floor2))
                      ? nrcw_pkg::THRESH_BITS'(floor2) : half_cwnd;
  assign clamped    = (work_cwnd > nrcw_pkg::WORK_BITS'(nrcw_pkg::WINDOW_CEILING))
                      ? nrcw_pkg::WINDOW_CEILING : work_cwnd[nrcw_pkg::CWND_BITS-1:0];

  assign status.kind       = item_kind;
  assign status.stale      = in_recovery && (item_sent <= recovery_start);
  assign status.limited    = item_limited;
  assign status.slow_start = nrcw_pkg::THRESH_BITS'(cwnd) < ssthresh;
  assign status.credit_ge  = work_credit >= work_cwnd;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_kind    <= nrcw_pkg::kind_t'(kind);
      item_bytes   <= packet_bytes;
      item_sent    <= packet_sent_time;
      item_now     <= now_time;
      item_limited <= app_limited;
    end
    if (cmd.ack_slow) begin
      work_cwnd   <= nrcw_pkg::WORK_BITS'(cwnd) + nrcw_pkg::WORK_BITS'(item_bytes);
      work_credit <= nrcw_pkg::WORK_BITS'(credit);
    end else if (cmd.ack_avoid) begin
      work_cwnd   <= nrcw_pkg::WORK_BITS'(cwnd);
      work_credit <= nrcw_pkg::WORK_BITS'(credit) + nrcw_pkg::WORK_BITS'(item_bytes);
    end else if (cmd.loop_step) begin
      // one datagram of growth per full window of credit
      work_cwnd   <= work_cwnd + nrcw_pkg::WORK_BITS'(max_datagram);
      work_credit <= work_credit - work_cwnd;
    end
    if (cmd.publish) begin
      cwnd_bytes           <= cwnd;
      slow_start_threshold <= ssthresh;
      recovering           <= in_recovery;
      cut_applied          <= cut_flag;
      cut_count            <= cuts_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cwnd           <= nrcw_pkg::RESET_WINDOW;
      ssthresh       <= nrcw_pkg::THRESH_UNLIMITED;
      credit         <= '0;
      in_recovery    <= 1'b0;
      recovery_start <= '0;
      cuts_total     <= '0;
      cut_flag       <= 1'b0;
    end else begin
      if (cmd.latch) begin
        cut_flag <= 1'b0;
      end
      if (cmd.clamp) begin
        cwnd   <= clamped;
        credit <= work_credit[nrcw_pkg::CREDIT_BITS-1:0];
      end
      if (cmd.cut) begin
        in_recovery    <= 1'b1;
        recovery_start <= item_now;
        ssthresh       <= cut_thresh;
        cwnd           <= nrcw_pkg::CWND_BITS'(cut_thresh);
        credit         <= '0;
        cuts_total     <= cuts_total + 1'b1;
        cut_flag       <= 1'b1;
      end
      if (cmd.collapse) begin
        cwnd        <= nrcw_pkg::CWND_BITS'(floor2);
        credit      <= '0;
        in_recovery <= 1'b0;
      end
      if (cmd.restart) begin
        cwnd           <= nrcw_pkg::initial_window(max_datagram);
        ssthresh       <= nrcw_pkg::THRESH_UNLIMITED;
        credit         <= '0;
        in_recovery    <= 1'b0;
        recovery_start <= '0;
      end
    end
  end

endmodule

FILE: rtl/newreno_congestion_window_core.sv
// channel  | handshake          | payload
// in       | in_valid/in_ready   | kind, packet_bytes, packet_sent_time, now_time, app_limited
// out      | out_valid/out_ready | cwnd_bytes, slow_start_threshold, recovering, cut_applied,
//          |                     | cut_count
// config   | apb write/read      | max_datagram at byte address 0
//
// one item at a time; in_ready is high only while the controller is idle
// congestion signal, persistent congestion, path reset and skipped acks: idle, exec, finish
// slow-start ack: idle, exec, clamp, finish; avoidance ack: idle, exec, loop, clamp, finish,
// with one loop step per datagram of growth in the credit subtract loop, one step a cycle
// the result sits in an output register, so the next item is taken while it waits
// synchronous active-high reset restores the initial window, unlimited ssthresh and md 1200
module newreno_congestion_window_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        kind,
  input  logic [nrcw_pkg::BYTES_BITS-1:0]   packet_bytes,
  input  logic [nrcw_pkg::TIME_BITS-1:0]    packet_sent_time,
  input  logic [nrcw_pkg::TIME_BITS-1:0]    now_time,
  input  logic                              app_limited,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nrcw_pkg::CWND_BITS-1:0]    cwnd_bytes,
  output logic [nrcw_pkg::THRESH_BITS-1:0]  slow_start_threshold,
  output logic                              recovering,
  output logic                              cut_applied,
  output logic [nrcw_pkg::COUNT_BITS-1:0]   cut_count,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nrcw_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [nrcw_pkg::DATA_BITS-1:0]    pwdata,
  output logic [nrcw_pkg::DATA_BITS-1:0]    prdata,
  output logic                              pready
);

  logic [nrcw_pkg::MD_BITS-1:0] max_datagram;
  logic                         md_hit;
  logic                         md_write;
  nrcw_pkg::dp_cmd_t            cmd;
  nrcw_pkg::dp_status_t         status;

  assign pready   = 1'b1;
  assign md_hit   = (paddr[nrcw_pkg::ADDR_BITS-1:2] == nrcw_pkg::REG_MAX_DATAGRAM);
  // a zero datagram size is ignored
  assign md_write = psel && penable && pwrite && pready && md_hit
                    && (pwdata[nrcw_pkg::MD_BITS-1:0] != '0);
  assign prdata   = md_hit ? nrcw_pkg::DATA_BITS'(max_datagram) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_datagram <= nrcw_pkg::RESET_DATAGRAM;
    end else if (md_write) begin
      max_datagram <= pwdata[nrcw_pkg::MD_BITS-1:0];
    end
  end

  nrcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  nrcw_dp u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .max_datagram         (max_datagram),
    .kind                 (kind),
    .packet_bytes         (packet_bytes),
    .packet_sent_time     (packet_sent_time),
    .now_time             (now_time),
    .app_limited          (app_limited),
    .cwnd_bytes           (cwnd_bytes),
    .slow_start_threshold (slow_start_threshold),
    .recovering           (recovering),
    .cut_applied          (cut_applied),
    .cut_count            (cut_count)
  );

endmodule
